/* hdl/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the WAV stream parser and mono downmix.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_EXT  = 16'hFFFE;
    localparam logic [31:0] MIN_HDR_BYTES = 32'd44;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_HEADER     = 2'd0;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd1;
    localparam logic [1:0] ERR_FORMAT     = 2'd2;

    // Word from the parser to the sample unit.
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_INFO   = 2'd1,
        CMD_ERROR  = 2'd2
    } cmd_t;

    // A sample word carries the format of its own file.
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] raw;
        logic        last_ch;
        logic [31:0] rate;
        logic [3:0]  chan;
        logic [1:0]  err;
        logic [15:0] code;
        logic [15:0] bits;
        logic [15:0] nch;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample;
        logic [31:0] rate;
        logic [3:0]  chan;
        logic [1:0]  err;
    } result_t;

endpackage

/* hdl/wsp_front.sv */
// ----------------------------------------------------------------------------
// wsp_front
// Byte parser: header and chunk walk, fmt capture, sample assembly.
// ----------------------------------------------------------------------------
module wsp_front #(
    parameter int MAX_CHANNELS = wsp_pkg::MAX_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          end_of_file,
    output logic          job_valid,
    input  logic          job_ready,
    output wsp_pkg::job_t job
);

    typedef enum logic [5:0] {
        PH_RIFF = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_FMT  = 6'b000100,
        PH_SKIP = 6'b001000,
        PH_PAD  = 6'b010000,
        PH_DATA = 6'b100000
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [31:0]   cnt_reg, cnt_next;
    logic [31:0]   tag_reg, tag_next;
    logic [31:0]   len_reg, len_next;
    logic [15:0]   code_reg, code_next;
    logic [15:0]   chan_reg, chan_next;
    logic [31:0]   rate_reg, rate_next;
    logic [15:0]   bits_reg, bits_next;
    logic [31:0]   rem_reg, rem_next;
    logic [63:0]   shift_reg, shift_next;
    logic [15:0]   chidx_reg, chidx_next;
    logic          done_reg, done_next;
    logic          emit;
    wsp_pkg::job_t emit_job;

    logic [31:0] cnt_inc, rem_dec, off;
    logic [12:0] bps;

    assign in_ready  = job_ready;
    assign job_valid = in_valid && job_ready && emit;
    assign job       = emit_job;

    assign cnt_inc = (cnt_reg == 32'hFFFF_FFFF) ? cnt_reg : cnt_reg + 32'd1;
    assign rem_dec = rem_reg - 32'd1;
    assign off     = len_reg - rem_reg;
    assign bps     = bits_reg[15:3];

    // Decode one byte.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        chidx_next = chidx_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        emit_job   = '0;
        emit_job.cmd = wsp_pkg::CMD_ERROR;
        if (!done_reg)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    cnt_next = cnt_inc;
                    tag_next = {data_byte, tag_reg[31:8]};
                    if (cnt_inc == 32'd4 && tag_next != wsp_pkg::TAG_RIFF)
                    begin
                        emit = 1'b1; done_next = 1'b1;
                        emit_job.err = wsp_pkg::ERR_HEADER;
                    end
                    else if (cnt_inc == 32'd12)
                    begin
                        if (tag_next != wsp_pkg::TAG_WAVE)
                        begin
                            emit = 1'b1; done_next = 1'b1;
                            emit_job.err = wsp_pkg::ERR_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_HDR; rem_next = 32'd8;
                        end
                    end
                end
                PH_HDR:
                begin
                    cnt_next = cnt_inc;
                    if (rem_reg > 32'd4) tag_next = {data_byte, tag_reg[31:8]};
                    else len_next = {data_byte, len_reg[31:8]};
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (tag_next == wsp_pkg::TAG_FMT || tag_next != wsp_pkg::TAG_DATA)
                        begin
                            if (tag_next == wsp_pkg::TAG_FMT)
                            begin
                                code_next = '0; chan_next = '0;
                                rate_next = '0; bits_next = '0;
                            end
                            if (len_next == 32'd0)
                            begin
                                phase_next = len_next[0] ? PH_PAD : PH_HDR;
                                rem_next   = 32'd8;
                            end
                            else
                            begin
                                phase_next = (tag_next == wsp_pkg::TAG_FMT) ? PH_FMT : PH_SKIP;
                                rem_next   = len_next;
                            end
                        end
                        else if (chan_reg == '0 || bits_reg == '0 || rate_reg == '0 ||
                                 len_next == '0 || end_of_file)
                        begin
                            emit = 1'b1; done_next = 1'b1;
                            emit_job.err = wsp_pkg::ERR_INCOMPLETE;
                        end
                        else if ((code_reg != 16'd1 && code_reg != 16'd3) ||
                                 bits_reg < 16'd8 || {16'd0, chan_reg} > MAX_CHANNELS)
                        begin
                            emit = 1'b1; done_next = 1'b1;
                            emit_job.err = wsp_pkg::ERR_FORMAT;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            rem_next   = len_next;
                            cnt_next   = '0;
                            shift_next = '0;
                            chidx_next = '0;
                            emit       = 1'b1;
                            emit_job.cmd  = wsp_pkg::CMD_INFO;
                            emit_job.rate = rate_reg;
                            emit_job.chan = chan_reg[3:0];
                        end
                    end
                end
                PH_FMT:
                begin
                    cnt_next = cnt_inc;
                    case (off)
                        32'd0:  code_next = {8'd0, data_byte};
                        32'd1:  code_next = {data_byte, code_reg[7:0]};
                        32'd2:  chan_next = {8'd0, data_byte};
                        32'd3:  chan_next = {data_byte, chan_reg[7:0]};
                        32'd4:  rate_next[7:0]   = data_byte;
                        32'd5:  rate_next[15:8]  = data_byte;
                        32'd6:  rate_next[23:16] = data_byte;
                        32'd7:  rate_next[31:24] = data_byte;
                        32'd14: bits_next = {8'd0, data_byte};
                        32'd15: bits_next = {data_byte, bits_reg[7:0]};
                        32'd24: tag_next  = {24'd0, data_byte};
                        32'd25:
                        begin
                            if (code_reg == wsp_pkg::FMT_EXT)
                                code_next = {data_byte, tag_reg[7:0]};
                        end
                        default: ;
                    endcase
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next = len_reg[0] ? PH_PAD : PH_HDR;
                        rem_next   = 32'd8;
                    end
                end
                PH_SKIP:
                begin
                    cnt_next = cnt_inc;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next = len_reg[0] ? PH_PAD : PH_HDR;
                        rem_next   = 32'd8;
                    end
                end
                PH_PAD:
                begin
                    cnt_next   = cnt_inc;
                    phase_next = PH_HDR;
                    rem_next   = 32'd8;
                end
                PH_DATA:
                begin
                    if (cnt_reg < 32'd8)
                        shift_next = shift_reg | ({56'd0, data_byte} << {cnt_reg[2:0], 3'b000});
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_next >= {19'd0, bps})
                    begin
                        emit         = 1'b1;
                        emit_job.cmd = wsp_pkg::CMD_SAMPLE;
                        emit_job.raw = shift_next;
                        emit_job.last_ch = (chidx_reg + 16'd1 >= chan_reg);
                        emit_job.code = code_reg;
                        emit_job.bits = bits_reg;
                        emit_job.nch  = chan_reg;
                        cnt_next   = '0;
                        shift_next = '0;
                        chidx_next = emit_job.last_ch ? 16'd0 : chidx_reg + 16'd1;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) done_next = 1'b1;
                end
                default: ;
            endcase
        end
        if (end_of_file)
        begin
            if (!emit && !done_next && phase_next != PH_DATA)
            begin
                emit = 1'b1;
                emit_job = '0;
                emit_job.cmd = wsp_pkg::CMD_ERROR;
                emit_job.err = (cnt_next < wsp_pkg::MIN_HDR_BYTES) ?
                               wsp_pkg::ERR_HEADER : wsp_pkg::ERR_INCOMPLETE;
            end
            phase_next = PH_RIFF;
            cnt_next = '0; tag_next = '0; len_next = '0;
            code_next = '0; chan_next = '0; rate_next = '0; bits_next = '0;
            rem_next = '0; shift_next = '0; chidx_next = '0; done_next = 1'b0;
        end
    end

    // Advance parser state on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            code_reg  <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            rem_reg   <= '0;
            shift_reg <= '0;
            chidx_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (in_valid && job_ready)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            code_reg  <= code_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
            chidx_reg <= chidx_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* hdl/wsp_queue.sv */
// ----------------------------------------------------------------------------
// wsp_queue
// Small FIFO between the parser and the sample unit.
// ----------------------------------------------------------------------------
module wsp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  wsp_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output wsp_pkg::job_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    wsp_pkg::job_t   mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign wr_ready = (cnt_reg != DEPTH[AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Store words.
    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    // Advance pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
        end
    end

endmodule

/* hdl/wsp_back.sv */
// ----------------------------------------------------------------------------
// wsp_back
// Sample conversion to Q1.31, frame accumulate, serial divide, result register.
// ----------------------------------------------------------------------------
module wsp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  wsp_pkg::job_t    job,
    output logic             res_valid,
    input  logic             res_ready,
    output wsp_pkg::result_t res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t           st_reg;
    logic signed [38:0] sum_reg;
    logic [38:0]      quo_reg, rem_reg;
    logic             neg_reg;
    logic [5:0]       step_reg;
    logic [15:0]      div_reg;
    wsp_pkg::result_t res_reg;
    wsp_pkg::result_t res_smp, res_cmd;
    logic signed [38:0] q31, sum_new;
    logic [38:0]      mag, trial, quo_new, rem_new;
    logic             quo_bit;

    // Convert a raw sample to Q1.31.
    function automatic logic signed [38:0] to_q31(logic [63:0] raw, logic [15:0] code,
                                                 logic [15:0] bits);
        logic [7:0]  e8;
        logic [10:0] e11;
        logic [38:0] m;
        logic        neg;
        logic signed [38:0] v;
        v = '0;
        if (code == 16'd3 && bits == 16'd32)
        begin
            neg = raw[31]; e8 = raw[30:23];
            m = {15'd0, 1'b1, raw[22:0]};
            if (e8 == 8'd0 || (e8 == 8'hFF && raw[22:0] != '0)) v = '0;
            else if (e8 >= 8'd127) v = neg ? -39'sd2147483648 : 39'sd2147483647;
            else
            begin
                if (e8 >= 8'd119) m = m << (e8 - 8'd119);
                else if (8'd119 - e8 >= 8'd32) m = '0;
                else m = m >> (8'd119 - e8);
                v = neg ? -$signed(m) : $signed(m);
            end
        end
        else if (code == 16'd3 && bits == 16'd64)
        begin
            neg = raw[63]; e11 = raw[62:52];
            if (e11 == 11'd0 || (e11 == 11'h7FF && raw[51:0] != '0)) v = '0;
            else if (e11 >= 11'd1023) v = neg ? -39'sd2147483648 : 39'sd2147483647;
            else if (11'd1044 - e11 >= 11'd64) v = '0;
            else
            begin
                m = 39'({11'd0, 1'b1, raw[51:0]} >> (11'd1044 - e11));
                v = neg ? -$signed(m) : $signed(m);
            end
        end
        else if (code == 16'd3) v = '0;
        else
        begin
            case (bits)
                16'd8:  v = {{8{~raw[7]}}, raw[6:0], 24'd0};
                16'd16: v = {{7{raw[15]}}, raw[15:0], 16'd0};
                16'd24: v = {{7{raw[23]}}, raw[23:0], 8'd0};
                16'd32: v = {{7{raw[31]}}, raw[31:0]};
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    assign q31       = to_q31(job.raw, job.code, job.bits);
    assign sum_new   = sum_reg + q31;
    assign job_ready = (st_reg == ST_IDLE);
    assign res_valid = (st_reg == ST_OUT);
    assign res       = res_reg;
    assign mag       = sum_new[38] ? 39'(-sum_new) : 39'(sum_new);
    assign trial     = {rem_reg[37:0], quo_reg[38]};
    assign quo_bit   = (trial >= {23'd0, div_reg});
    assign rem_new   = quo_bit ? trial - {23'd0, div_reg} : trial;
    assign quo_new   = {quo_reg[37:0], quo_bit};

    // Build the sample word and the info or error word.
    always_comb
    begin
        res_smp        = '0;
        res_smp.kind   = wsp_pkg::KIND_SAMPLE;
        res_smp.sample = neg_reg ? 32'(-quo_new) : quo_new[31:0];
        res_cmd        = '0;
        res_cmd.kind   = (job.cmd == wsp_pkg::CMD_INFO) ?
                         wsp_pkg::KIND_INFO : wsp_pkg::KIND_ERROR;
        res_cmd.rate   = job.rate;
        res_cmd.chan   = job.chan;
        res_cmd.err    = job.err;
    end

    // Accumulate, divide one bit a cycle, hold the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            sum_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            div_reg  <= '0;
            res_reg  <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job.cmd == wsp_pkg::CMD_SAMPLE)
                        begin
                            if (job.last_ch)
                            begin
                                sum_reg  <= '0;
                                neg_reg  <= sum_new[38];
                                quo_reg  <= mag;
                                rem_reg  <= '0;
                                div_reg  <= job.nch;
                                step_reg <= '0;
                                st_reg   <= ST_DIV;
                            end
                            else sum_reg <= sum_new;
                        end
                        else
                        begin
                            sum_reg <= '0;
                            res_reg <= res_cmd;
                            st_reg  <= ST_OUT;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_new;
                    quo_reg  <= quo_new;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd38)
                    begin
                        res_reg <= res_smp;
                        st_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (res_ready) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hdl/wav_stream_parser_downmix_core.sv */
// ----------------------------------------------------------------------------
// wav_stream_parser_downmix_core
// WAV byte stream parser with mono downmix, queue interfaces on both sides.
// ----------------------------------------------------------------------------
// A byte is taken each cycle while the job queue has room. The back end takes
// no new word while it divides or holds a result, and a frame's mean comes from the
// bit-serial divider that divides the channel sum by the channel count.
// Samples are 8/16/24/32-bit PCM or 32/64-bit float, returned as Q1.31.
module wav_stream_parser_downmix_core #(
    parameter int MAX_CHANNELS = wsp_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  item_kind,
    output logic signed [31:0] mono_sample,
    output logic [31:0] rate_hz,
    output logic [3:0]  channel_count,
    output logic [1:0]  error_code
);

    logic             in_ready, fj_valid, fj_ready, bj_valid, bj_ready, res_valid;
    wsp_pkg::job_t    fj, bj;
    wsp_pkg::result_t res;

    assign full  = !in_ready;
    assign empty = !res_valid;
    assign item_kind     = res.kind;
    assign mono_sample   = res.sample;
    assign rate_hz       = res.rate;
    assign channel_count = res.chan;
    assign error_code    = res.err;

    wsp_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_ready(in_ready),
        .data_byte(data_byte), .end_of_file(end_of_file),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    // Hold parser words until the sample unit takes them; each sample word
    // carries the format of its own file.
    wsp_queue #(.DEPTH(4)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready),
        .wr_data(fj), .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    wsp_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready),
        .job(bj), .res_valid(res_valid), .res_ready(pop), .res(res)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WAV stream parser: builds WAV files byte by
// byte, predicts the info, error and mono sample words, and compares them.
// ----------------------------------------------------------------------------

typedef struct {
    logic [1:0]  kind;
    logic [31:0] sample;
    logic [31:0] rate;
    logic [3:0]  chan;
    logic [1:0]  err;
} wav_word_t;

class wav_scoreboard;
    // parser state
    int unsigned phase;
    logic [31:0] nbytes, tag, clen, rate, remain;
    logic [15:0] fmt, chans, bits;
    logic [63:0] shreg;
    int unsigned chidx;
    longint      fsum;
    bit          done;
    wav_word_t   pending[$];
    int          errors;

    localparam int P_RIFF = 0, P_HDR = 1, P_FMT = 2, P_SKIP = 3, P_PAD = 4,
        P_DATA = 5;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        phase = P_RIFF; nbytes = 0; tag = 0; clen = 0; rate = 0; remain = 0;
        fmt = 0; chans = 0; bits = 0; shreg = 0; chidx = 0; fsum = 0; done = 0;
    endfunction

    function void emit(logic [1:0] k, logic [31:0] s, logic [31:0] r,
                       logic [3:0] c, logic [1:0] e);
        wav_word_t w;
        w.kind = k; w.sample = s; w.rate = r; w.chan = c; w.err = e;
        pending.push_back(w);
    endfunction

    function void fail_word(logic [1:0] code);
        done = 1;
        emit(wsp_pkg::KIND_ERROR, 0, 0, 0, code);
    endfunction

    function void body_end();
        if (clen[0]) phase = P_PAD;
        else
        begin
            phase = P_HDR; remain = 8;
        end
    endfunction

    function void bump();
        if (nbytes != 32'hFFFF_FFFF) nbytes++;
    endfunction

    // convert one raw sample to Q1.31
    function longint to_fixed(logic [63:0] raw);
        longint mag;
        int unsigned ex;
        bit neg;
        if (fmt == 3 && bits == 32)
        begin
            neg = raw[31]; ex = raw[30:23];
            if (ex == 255 && raw[22:0] != 0) return 0;
            if (ex == 0) return 0;
            if (ex >= 127) return neg ? -64'sd2147483648 : 64'sd2147483647;
            if (ex >= 119) mag = longint'({1'b1, raw[22:0]}) << (ex - 119);
            else mag = (119 - ex) >= 32 ? 0 : longint'({1'b1, raw[22:0]}) >> (119 - ex);
            return neg ? -mag : mag;
        end
        if (fmt == 3 && bits == 64)
        begin
            neg = raw[63]; ex = raw[62:52];
            if (ex == 2047 && raw[51:0] != 0) return 0;
            if (ex == 0) return 0;
            if (ex >= 1023) return neg ? -64'sd2147483648 : 64'sd2147483647;
            mag = (1044 - ex) >= 64 ? 0 : longint'({1'b1, raw[51:0]} >> (1044 - ex));
            return neg ? -mag : mag;
        end
        if (fmt == 3) return 0;
        case (bits)
            8:  return (longint'(raw[7:0]) - 128) * 16777216;
            16: return longint'($signed(raw[15:0])) * 65536;
            24: return longint'($signed(raw[23:0])) * 256;
            32: return longint'($signed(raw[31:0]));
            default: return 0;
        endcase
    endfunction

    function bit header_end(bit eof);
        if (tag == wsp_pkg::TAG_FMT)
        begin
            fmt = 0; chans = 0; rate = 0; bits = 0;
            if (clen == 0) body_end();
            else
            begin
                phase = P_FMT; remain = clen;
            end
            return 0;
        end
        if (tag == wsp_pkg::TAG_DATA)
        begin
            if (chans == 0 || bits == 0 || rate == 0 || clen == 0 || eof)
            begin
                fail_word(wsp_pkg::ERR_INCOMPLETE); return 1;
            end
            if ((fmt != 1 && fmt != 3) || bits < 8 || chans > wsp_pkg::MAX_CHANNELS_DEF)
            begin
                fail_word(wsp_pkg::ERR_FORMAT); return 1;
            end
            phase = P_DATA; remain = clen; nbytes = 0; shreg = 0; chidx = 0; fsum = 0;
            emit(wsp_pkg::KIND_INFO, 0, rate, chans[3:0], 0);
            return 1;
        end
        if (clen == 0) body_end();
        else
        begin
            phase = P_SKIP; remain = clen;
        end
        return 0;
    endfunction

    function void capture_fmt(logic [31:0] off, logic [7:0] b);
        if (off == 0) fmt = b;
        else if (off == 1) fmt[15:8] = b;
        else if (off == 2) chans = b;
        else if (off == 3) chans[15:8] = b;
        else if (off >= 4 && off <= 7) rate = rate | (32'(b) << (8 * (off - 4)));
        else if (off == 14) bits = b;
        else if (off == 15) bits[15:8] = b;
        else if (off == 24) tag = b;
        else if (off == 25 && fmt == wsp_pkg::FMT_EXT) fmt = {b, tag[7:0]};
    endfunction

    // note one accepted byte
    function void note_byte(logic [7:0] b, bit eof);
        bit got;
        longint mean;
        got = 0;
        if (!done)
        begin
            case (phase)
                P_RIFF:
                begin
                    bump();
                    tag = {b, tag[31:8]};
                    if (nbytes == 4 && tag != wsp_pkg::TAG_RIFF)
                    begin
                        fail_word(wsp_pkg::ERR_HEADER); got = 1;
                    end
                    else if (nbytes == 12)
                    begin
                        if (tag != wsp_pkg::TAG_WAVE)
                        begin
                            fail_word(wsp_pkg::ERR_HEADER); got = 1;
                        end
                        else
                        begin
                            phase = P_HDR; remain = 8;
                        end
                    end
                end
                P_HDR:
                begin
                    bump();
                    if (remain > 4) tag = {b, tag[31:8]};
                    else clen = {b, clen[31:8]};
                    remain--;
                    if (remain == 0) got = header_end(eof);
                end
                P_FMT:
                begin
                    bump();
                    capture_fmt(clen - remain, b);
                    remain--;
                    if (remain == 0) body_end();
                end
                P_SKIP:
                begin
                    bump();
                    remain--;
                    if (remain == 0) body_end();
                end
                P_PAD:
                begin
                    bump();
                    phase = P_HDR; remain = 8;
                end
                default:
                begin
                    if (nbytes < 8) shreg = shreg | (64'(b) << (8 * nbytes));
                    nbytes++;
                    if (nbytes >= bits / 8)
                    begin
                        fsum += to_fixed(shreg);
                        nbytes = 0; shreg = 0; chidx++;
                        if (chidx >= chans)
                        begin
                            mean = fsum / longint'(chans);
                            emit(wsp_pkg::KIND_SAMPLE, mean[31:0], 0, 0, 0);
                            got = 1; chidx = 0; fsum = 0;
                        end
                    end
                    remain--;
                    if (remain == 0) done = 1;
                end
            endcase
        end
        if (eof)
        begin
            if (!got && !done && phase != P_DATA)
                fail_word(nbytes < 44 ? wsp_pkg::ERR_HEADER : wsp_pkg::ERR_INCOMPLETE);
            clear();
        end
    endfunction

    // check one popped word against the oldest prediction
    function void check_word(wav_word_t got);
        wav_word_t exp_w;
        if (pending.size() == 0)
        begin
            $error("unexpected word kind=%0d", got.kind);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.kind !== exp_w.kind)
        begin
            $error("item_kind exp %0d got %0d", exp_w.kind, got.kind); errors++;
        end
        if (got.sample !== exp_w.sample)
        begin
            $error("mono_sample exp %h got %h", exp_w.sample, got.sample); errors++;
        end
        if (got.rate !== exp_w.rate)
        begin
            $error("rate_hz exp %0d got %0d", exp_w.rate, got.rate); errors++;
        end
        if (got.chan !== exp_w.chan)
        begin
            $error("channel_count exp %0d got %0d", exp_w.chan, got.chan); errors++;
        end
        if (got.err !== exp_w.err)
        begin
            $error("error_code exp %0d got %0d", exp_w.err, got.err); errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        end_of_file;
    logic        empty;
    logic        pop;
    logic [1:0]  item_kind;
    logic signed [31:0] mono_sample;
    logic [31:0] rate_hz;
    logic [3:0]  channel_count;
    logic [1:0]  error_code;

    wav_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  bytes_sent;
    byte unsigned file_buf[$];

    wav_stream_parser_downmix_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .end_of_file(end_of_file),
        .empty(empty), .pop(pop), .item_kind(item_kind),
        .mono_sample(mono_sample), .rate_hz(rate_hz),
        .channel_count(channel_count), .error_code(error_code)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // send one byte, holding it until accepted; the caller drops push when done
    task automatic send_byte(logic [7:0] b, bit eof);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1; data_byte <= b; end_of_file <= eof;
        do @(posedge clk); while (full);
        board.note_byte(b, eof);
        bytes_sent++;
        @(negedge clk);
    endtask

    // send the assembled file, marking the last byte
    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
    endtask

    task automatic add_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic add_riff();
        add_le(wsp_pkg::TAG_RIFF, 4); add_le($urandom, 4); add_le(wsp_pkg::TAG_WAVE, 4);
    endtask

    task automatic add_fmt(logic [15:0] f, logic [15:0] ch, logic [31:0] r,
                           logic [15:0] b, bit ext);
        add_le(wsp_pkg::TAG_FMT, 4); add_le(ext ? 40 : 16, 4);
        add_le(ext ? wsp_pkg::FMT_EXT : f, 2); add_le(ch, 2); add_le(r, 4);
        add_le($urandom, 4); add_le($urandom, 2); add_le(b, 2);
        if (ext)
        begin
            add_le($urandom, 4); add_le($urandom, 4); add_le(f, 2);
            add_le($urandom, 4); add_le($urandom, 4); add_le($urandom, 4);
            add_le($urandom, 2);
        end
    endtask

    task automatic add_junk(int len);
        add_le($urandom, 4); add_le(len, 4);
        for (int i = 0; i < len; i++) file_buf.push_back($urandom);
        if (len % 2) file_buf.push_back($urandom);
    endtask

    // random sample byte with an eye on float extremes
    function automatic byte unsigned sample_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(1) ? 8'h3F : 8'hBF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_data(int len, bit trail);
        add_le(wsp_pkg::TAG_DATA, 4); add_le(len, 4);
        for (int i = 0; i < len; i++) file_buf.push_back(sample_byte());
        if (trail)
            for (int i = $urandom_range(3); i > 0; i--) file_buf.push_back($urandom);
    endtask

    // well-formed file with random format and content
    task automatic random_file();
        int kind_sel, ch, bits, fmtv, frames;
        kind_sel = $urandom_range(5);
        ch = $urandom_range(1, 8);
        fmtv = 1;
        case (kind_sel)
            0: bits = 8;
            1: bits = 16;
            2: bits = 24;
            3: bits = 32;
            4:
            begin
                fmtv = 3; bits = 32;
            end
            default:
            begin
                fmtv = 3; bits = 64;
            end
        endcase
        frames = $urandom_range(1, 6);
        add_riff();
        if ($urandom_range(3) == 0) add_junk($urandom_range(0, 5));
        add_fmt(fmtv, ch, $urandom_range(1, 192000), bits, $urandom_range(3) == 0);
        add_data(frames * ch * bits / 8 + ($urandom_range(3) == 0 ? 1 : 0),
                 $urandom_range(1));
        send_file();
    endtask

    // broken or odd file
    task automatic noise_file();
        int n;
        case ($urandom_range(5))
            0:
            begin
                n = $urandom_range(1, 60);
                for (int i = 0; i < n; i++) file_buf.push_back($urandom);
            end
            1:
            begin
                add_riff(); add_fmt($urandom_range(4), $urandom_range(0, 12),
                    $urandom_range(1) ? 0 : $urandom, $urandom_range(0, 40), 0);
                add_data($urandom_range(0, 8), 0);
            end
            2:
            begin
                add_riff(); add_fmt(1, 2, 8000, 16, 0); add_le(wsp_pkg::TAG_DATA, 4);
                add_le($urandom_range(1, 9), 4);
            end
            3:
            begin
                add_riff(); add_junk($urandom_range(0, 40));
            end
            4:
            begin
                add_riff(); add_fmt(1, 1, 8000, 12, 0); add_data(6, 0);
            end
            default:
            begin
                add_riff();
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++) file_buf.push_back($urandom);
            end
        endcase
        send_file();
    endtask

    // pop side, with idles and one long hold
    initial
    begin
        wav_word_t w;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= !recv_hold && !($urandom_range(99) < recv_idle_pct);
            @(posedge clk);
            if (pop && !empty)
            begin
                w.kind = item_kind; w.sample = mono_sample; w.rate = rate_hz;
                w.chan = channel_count; w.err = error_code;
                board.check_word(w);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int spin;
        board = new();
        push = 1'b0; data_byte = 8'h00; end_of_file = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0; bytes_sent = 0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: header errors, 8/16/24-bit PCM, 32/64-bit float and odd formats, extremes
        file_buf = '{8'h52, 8'h49, 8'h46, 8'h58}; send_file();
        add_le(wsp_pkg::TAG_RIFF, 4); add_le(0, 4); add_le(32'h4556_41FF, 4); send_file();
        add_riff(); add_fmt(1, 8, 32'hFFFF_FFFF, 8, 0);
        add_le(wsp_pkg::TAG_DATA, 4); add_le(8, 4);
        add_le(32'h80FF_7F00, 4); add_le(32'h0180_FF00, 4); send_file();
        add_riff(); add_fmt(3, 1, 44100, 32, 0); add_data(0, 0); send_file();
        for (int i = 0; i < 8; i++)
        begin
            add_riff(); add_fmt(i < 4 ? 1 : 3, 2, 48000,
                i == 0 ? 8 : i == 1 ? 16 : i == 2 ? 24 : i == 4 ? 16 : 32 << (i % 2), i == 5);
            add_data(24, 1);
            send_file();
        end
        // float saturation and NaN
        add_riff(); add_fmt(3, 1, 8000, 32, 0); add_le(wsp_pkg::TAG_DATA, 4); add_le(12, 4);
        add_le(32'h3F80_0000, 4); add_le(32'hBF80_0000, 4); add_le(32'h7FC0_0000, 4);
        send_file();

        // sender idles 18, receiver 79
        send_idle_pct = 18; recv_idle_pct = 79;
        while (bytes_sent < 560)
            if ($urandom_range(4) == 0) noise_file(); else random_file();

        // long receiver hold while bytes keep coming
        recv_hold = 1;
        fork
            begin
                for (spin = 0; spin < 400; spin++) @(negedge clk);
                recv_hold = 0;
            end
            begin
                do random_file(); while (recv_hold);
            end
        join

        send_idle_pct = 79; recv_idle_pct = 18;
        while (bytes_sent < 1100)
            if ($urandom_range(4) == 0) noise_file(); else random_file();
        send_idle_pct = 0; recv_idle_pct = 0;
        while (bytes_sent < 1500)
            if ($urandom_range(4) == 0) noise_file(); else random_file();
        push <= 1'b0;

        // drain
        spin = 0;
        while (board.pending.size() != 0 && spin < 100000)
        begin
            @(negedge clk); spin++;
        end
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
